// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
// Every macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high
`define SMCN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds across reset
`define SMCN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/smcn_pkg.sv -----
// Shared constants, codes, types for the sensor min/max calibrate and normalize block.
// No dependencies; imported by every module of the block.
`default_nettype none

package smcn_pkg;

  // Sizing
  localparam int CHANNELS    = 6;
  localparam int SAMPLE_BITS = 10;
  localparam int CH_W        = 3;
  localparam int VAL_W       = 10;
  localparam int LEVEL_W     = 21;
  localparam int NUM_W       = 20;
  localparam int DEN_W       = 10;
  localparam int CNT_W       = $clog2(NUM_W + 1);
  localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_EXT_W    = 5;

  // Sample mask and store reset values
  localparam logic [VAL_W-1:0] SMP_MASK  = VAL_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [VAL_W-1:0] FULL_CODE = SMP_MASK;

  // Scale targets
  localparam logic [VAL_W-1:0] TOP_SMALL = 10'd100;
  localparam logic [VAL_W-1:0] TOP_MID   = 10'd500;
  localparam logic [VAL_W-1:0] TOP_FULL  = 10'd1023;

  // Request codes
  localparam logic [1:0] REQ_CAL  = 2'd0;
  localparam logic [1:0] REQ_NORM = 2'd1;
  localparam logic [1:0] REQ_CLR  = 2'd2;

  // Scale modes
  localparam logic [1:0] MODE_P100 = 2'd0;
  localparam logic [1:0] MODE_P500 = 2'd1;
  localparam logic [1:0] MODE_FULL = 2'd2;
  localparam logic [1:0] MODE_RAW  = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_CALC,
    ST_DIV,
    ST_OUT
  } state_t;

  // Command to the calibration store
  typedef struct packed {
    logic                cal;
    logic                clr;
    logic                ok;
    logic [CH_IDX_W-1:0] idx;
    logic [VAL_W-1:0]    smp;
  } store_cmd_t;

  // Start request to the divider
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic             neg;
  } div_req_t;

  // Divider response
  typedef struct packed {
    logic                      done;
    logic signed [LEVEL_W-1:0] level;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/smcn_store.sv -----
// Per-channel minimum/maximum calibration registers with calibrate and clear-all.
// Depends on smcn_pkg.
`default_nettype none

module smcn_store import smcn_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire store_cmd_t       cmd,
  output logic      [VAL_W-1:0] rd_min,
  output logic      [VAL_W-1:0] rd_max
);

  logic [VAL_W-1:0] min_q [CHANNELS];
  logic [VAL_W-1:0] max_q [CHANNELS];

  // Clear sets the full range empty; calibrate widens one channel
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      for (int i = 0; i < CHANNELS; i++) begin
        min_q[i] <= FULL_CODE;
        max_q[i] <= '0;
      end
    end else if (cmd.cal && cmd.ok) begin
      if (cmd.smp < min_q[cmd.idx]) min_q[cmd.idx] <= cmd.smp;
      if (cmd.smp > max_q[cmd.idx]) max_q[cmd.idx] <= cmd.smp;
    end
  end

  // Read port; channels out of range read as zero
  assign rd_min = cmd.ok ? min_q[cmd.idx] : '0;
  assign rd_max = cmd.ok ? max_q[cmd.idx] : '0;

endmodule

`default_nettype wire

// ----- rtl/core/smcn_div.sv -----
// Restoring divider, one quotient bit per cycle, with sign applied at the end.
// Depends on smcn_pkg.
`default_nettype none

module smcn_div import smcn_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [CNT_W-1:0]   cnt;
  logic               done;
  logic [NUM_W-1:0]   quo;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W-1:0]   den;
  logic               neg;

  logic [DEN_W:0]     rem_sh;
  logic [DEN_W+1:0]   trial;
  logic [LEVEL_W-1:0] q_ext;

  // One trial subtraction per step
  assign rem_sh = {rem, quo[NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den};

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) done <= 1'b1;
      end
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num_mag;
      rem <= '0;
      den <= req.den_mag;
      neg <= req.neg;
    end else if (cnt != '0) begin
      if (!trial[DEN_W+1]) begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  // Truncation toward zero: magnitude quotient, then sign
  assign q_ext     = {{(LEVEL_W-NUM_W){1'b0}}, quo};
  assign rsp.done  = done;
  assign rsp.level = neg ? -q_ext : q_ext;

endmodule

`default_nettype wire

// ----- rtl/core/sensor_minmax_calibrate_normalize_top.sv -----
// Sensor min/max calibration and min-max normalization, top level with sequencer.
// Depends on smcn_pkg, smcn_store, smcn_div.
//
// One request is taken at a time. Calibrate, clear, raw passthrough and any
// normalize that needs no division pass through the update and calculate
// states to the output state; a normalize that divides also waits in the
// divide state for the 20-step restoring divider, which produces one quotient
// bit per cycle. The input side is ready again once the result is loaded into
// the output register. The output register may still wait for the downstream
// transfer, and a stalled result holds the next request back in the output
// state. Scaled levels are (sample-min)*top/(max-min) truncated toward zero,
// not clamped, so an uncalibrated channel or a sample outside its range can
// give a negative level or one above top.
`default_nettype none

module sensor_minmax_calibrate_normalize_top import smcn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: scale_mode
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [2:0] channel, [12:3] sample, [15:13] zero
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // [2:0] out_channel, [23:3] level,
                                          // [33:24] cur_min, [43:34] cur_max, rest zero
  output logic [0:0]       m_axis_tuser   // [0] div_zero
);

  state_t state, state_next;

  logic [1:0]         mode;
  logic [1:0]         req_r;
  logic [CH_W-1:0]    ch_r;
  logic [VAL_W-1:0]   smp_r;
  logic               ok_r;

  logic signed [LEVEL_W-1:0] level_r;
  logic               dz_r;
  logic [VAL_W-1:0]   cmin_r;
  logic [VAL_W-1:0]   cmax_r;

  logic [CH_W-1:0]    o_ch;
  logic [LEVEL_W-1:0] o_level;
  logic               o_dz;
  logic [VAL_W-1:0]   o_min;
  logic [VAL_W-1:0]   o_max;

  logic               in_xfer;
  logic               calc_en;
  logic               div_wait;
  logic               out_load;
  logic               need_div;

  store_cmd_t         store_cmd;
  logic [VAL_W-1:0]   rd_min;
  logic [VAL_W-1:0]   rd_max;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [CH_EXT_W-1:0] ch_ext;
  logic [CH_EXT_W-1:0] in_ch_ext;
  logic [VAL_W-1:0]    top_val;
  logic signed [VAL_W:0]     diff;
  logic signed [VAL_W:0]     den;
  logic signed [VAL_W:0]     den_neg;
  logic signed [LEVEL_W:0]   prod;
  logic signed [LEVEL_W-1:0] num;
  logic signed [LEVEL_W-1:0] num_neg;
  logic               is_norm;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign in_ch_ext = {{(CH_EXT_W-CH_W){1'b0}}, s_axis_tdata[2:0]};
  assign ch_ext    = {{(CH_EXT_W-CH_W){1'b0}}, ch_r};

  // Scale mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_P100;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= s_axis_tuser;
      ch_r  <= s_axis_tdata[2:0];
      smp_r <= s_axis_tdata[12:3] & SMP_MASK;
      ok_r  <= in_ch_ext < CH_EXT_W'(CHANNELS);
    end
  end

  // Calibration store
  always_comb begin
    store_cmd.cal = (state == ST_UPD) && (req_r == REQ_CAL);
    store_cmd.clr = (state == ST_UPD) && (req_r == REQ_CLR);
    store_cmd.ok  = ok_r;
    store_cmd.idx = ch_ext[CH_IDX_W-1:0];
    store_cmd.smp = smp_r;
  end

  smcn_store u_store (
    .clk    (clk),
    .rst    (rst),
    .cmd    (store_cmd),
    .rd_min (rd_min),
    .rd_max (rd_max)
  );

  // Numerator and denominator from the stored range
  always_comb begin
    unique case (mode)
      MODE_P100: top_val = TOP_SMALL;
      MODE_P500: top_val = TOP_MID;
      MODE_FULL: top_val = TOP_FULL;
      MODE_RAW:  top_val = TOP_FULL;
      default:   top_val = TOP_FULL;
    endcase
    diff    = $signed({1'b0, smp_r}) - $signed({1'b0, rd_min});
    den     = $signed({1'b0, rd_max}) - $signed({1'b0, rd_min});
    den_neg = -den;
    prod    = diff * $signed({1'b0, top_val});
    num     = prod[LEVEL_W-1:0];
    num_neg = -num;
    is_norm = (req_r == REQ_NORM);
    need_div = is_norm && (mode != MODE_RAW) && ok_r && (den != '0);
  end

  // Divider start
  always_comb begin
    div_req.start   = calc_en && need_div;
    div_req.num_mag = num[LEVEL_W-1] ? num_neg[NUM_W-1:0] : num[NUM_W-1:0];
    div_req.den_mag = den[VAL_W] ? den_neg[DEN_W-1:0] : den[DEN_W-1:0];
    div_req.neg     = num[LEVEL_W-1] ^ den[VAL_W];
  end

  smcn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Result fields
  always_ff @(posedge clk) begin
    if (calc_en) begin
      cmin_r  <= rd_min;
      cmax_r  <= rd_max;
      dz_r    <= is_norm && (mode != MODE_RAW) && ok_r && (den == '0);
      level_r <= (is_norm && (mode == MODE_RAW)) ?
                 $signed({{(LEVEL_W-VAL_W){1'b0}}, smp_r}) : '0;
    end else if (div_wait && div_rsp.done) begin
      level_r <= div_rsp.level;
    end
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = ST_UPD;
      ST_UPD:  state_next = ST_CALC;
      ST_CALC: state_next = need_div ? ST_DIV : ST_OUT;
      ST_DIV:  if (div_rsp.done) state_next = ST_OUT;
      ST_OUT:  if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    s_axis_tready = 1'b0;
    calc_en       = 1'b0;
    div_wait      = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_UPD:  ;
      ST_CALC: calc_en = 1'b1;
      ST_DIV:  div_wait = 1'b1;
      ST_OUT:  out_load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_ch    <= ch_r;
      o_level <= level_r;
      o_dz    <= dz_r;
      o_min   <= cmin_r;
      o_max   <= cmax_r;
    end
  end

  assign m_axis_tdata = {4'b0000, o_max, o_min, o_level, o_ch};
  assign m_axis_tuser = o_dz;

endmodule

`default_nettype wire

// ----- rtl/core/smcn_checker.sv -----
// Port-level checks for the sensor min/max calibrate and normalize top level.
// Depends on smcn_pkg and assert_macros.svh; bound to the top level below.
`default_nettype none

`include "assert_macros.svh"

module smcn_checker import smcn_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  logic [CH_EXT_W-1:0] out_ch_ext;
  assign out_ch_ext = {{(CH_EXT_W-CH_W){1'b0}}, m_axis_tdata[2:0]};

  // Stalled result holds
  `SMCN_ASSERT_RST(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // No result straight out of reset
  `SMCN_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_axis_tvalid, "result valid after reset")

  // One request in flight: input side closes after a transfer
  `SMCN_ASSERT_RST(a_one_req, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second request accepted while busy")

  // Division by zero always reports a zero level
  `SMCN_ASSERT_RST(a_dz_level, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[23:3] == '0, "nonzero level with div_zero")

  // Channels out of range report zero for cur_min and cur_max
  `SMCN_ASSERT_RST(a_bad_ch, m_axis_tvalid && (out_ch_ext >= CH_EXT_W'(CHANNELS)) |-> m_axis_tdata[43:24] == '0, "range reported for bad channel")

endmodule

bind sensor_minmax_calibrate_normalize_top smcn_checker u_smcn_checker (.*);

`default_nettype wire

// ----- verif/sensor_minmax_calibrate_normalize_checker.sv -----
// Checker for the sensor min/max calibrate and normalize block: watches the config
// port and both streams, predicts each result and compares it. Depends on smcn_pkg.
module sensor_minmax_calibrate_normalize_checker import smcn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [2:0] channel, [12:3] sample, [15:13] zero
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [47:0] m_axis_tdata,  // [2:0] out_channel, [23:3] level,
                                          // [33:24] cur_min, [43:34] cur_max
  input  wire logic [0:0]  m_axis_tuser,  // [0] div_zero
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [LEVEL_W-1:0] level;
    logic               dz;
    logic [VAL_W-1:0]   lo;
    logic [VAL_W-1:0]   hi;
  } reading_t;

  reading_t         readings_due[$];
  logic [1:0]       scale;
  logic [VAL_W-1:0] lo_cal[CHANNELS];
  logic [VAL_W-1:0] hi_cal[CHANNELS];

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Applies one request to the calibration copy and returns the reading it yields
  function automatic reading_t normalize_reading(logic [1:0] req, logic [CH_W-1:0] ch,
                                                 logic [VAL_W-1:0] smp);
    reading_t r;
    logic     ok;
    longint   top, lo, hi, span;
    int       i;
    r = '0;
    r.ch = ch;
    ok = (ch < CHANNELS);
    case (req)
      REQ_CLR: begin
        for (i = 0; i < CHANNELS; i++) begin
          lo_cal[i] = FULL_CODE;
          hi_cal[i] = '0;
        end
      end
      REQ_CAL: begin
        if (ok) begin
          if (smp < lo_cal[ch]) lo_cal[ch] = smp;
          if (smp > hi_cal[ch]) hi_cal[ch] = smp;
        end
      end
      REQ_NORM: begin
        if (scale == MODE_RAW) begin
          r.level = LEVEL_W'(smp);
        end else if (ok) begin
          top = longint'((scale == MODE_P100) ? TOP_SMALL :
                         (scale == MODE_P500) ? TOP_MID : TOP_FULL);
          lo = longint'(lo_cal[ch]);
          hi = longint'(hi_cal[ch]);
          span = hi - lo;
          // signed division truncates toward zero; no clamping
          if (span == 0) r.dz = 1'b1;
          else r.level = LEVEL_W'(((longint'(smp) - lo) * top) / span);
        end
      end
      default: ;  // unused code: nothing changes
    endcase
    if (ok) begin
      r.lo = lo_cal[ch];
      r.hi = hi_cal[ch];
    end
    return r;
  endfunction

  // Compare each result transfer with the oldest prediction
  task automatic check_result();
    reading_t want;
    if (readings_due.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected, data %h", m_axis_tdata));
      return;
    end
    want = readings_due.pop_front();
    if (m_axis_tdata[2:0] !== want.ch)
      report_mismatch($sformatf("channel %0d, want %0d", m_axis_tdata[2:0], want.ch));
    if (m_axis_tdata[23:3] !== want.level)
      report_mismatch($sformatf("ch %0d level %0d, want %0d", want.ch,
                                $signed(m_axis_tdata[23:3]), $signed(want.level)));
    if (m_axis_tuser[0] !== want.dz)
      report_mismatch($sformatf("ch %0d div_zero %b, want %b", want.ch, m_axis_tuser[0],
                                want.dz));
    if (m_axis_tdata[33:24] !== want.lo)
      report_mismatch($sformatf("ch %0d cur_min %0d, want %0d", want.ch, m_axis_tdata[33:24],
                                want.lo));
    if (m_axis_tdata[43:34] !== want.hi)
      report_mismatch($sformatf("ch %0d cur_max %0d, want %0d", want.ch, m_axis_tdata[43:34],
                                want.hi));
  endtask

  // Sample everything on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      scale = MODE_P100;
      for (int i = 0; i < CHANNELS; i++) begin
        lo_cal[i] = FULL_CODE;
        hi_cal[i] = '0;
      end
      readings_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready)
        readings_due.push_back(normalize_reading(s_axis_tuser, s_axis_tdata[2:0],
                                                 s_axis_tdata[12:3]));
      if (cfg_we) scale = cfg_wdata;
    end
    pending <= readings_due.size();
  end

endmodule

// ----- verif/sensor_minmax_calibrate_normalize_top_tb.sv -----
// Testbench top for the sensor min/max calibrate and normalize block: clock, reset,
// request and config stimulus, receiver stalls and verdict. Depends on smcn_pkg,
// the block's RTL and sensor_minmax_calibrate_normalize_checker.
module sensor_minmax_calibrate_normalize_top_tb;
  import smcn_pkg::*;

  localparam logic [1:0] REQ_NOP      = 2'd3;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         PHASES       = 8;
  localparam int         PHASE_ITEMS  = 175;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire [47:0]  m_axis_tdata;
  wire [0:0]   m_axis_tuser;

  int          errors;
  int          pending;
  bit          idling = 1'b1;
  int          hold = 0;
  int          quiet_cycles = 0;
  logic [1:0]  scale_order[4] = '{MODE_FULL, MODE_P500, MODE_RAW, MODE_P100};

  always #5 clk = ~clk;

  sensor_minmax_calibrate_normalize_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  sensor_minmax_calibrate_normalize_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors        (errors),
    .pending       (pending)
  );

  // Receiver: random stall bursts while idling is on
  always @(posedge clk) begin
    if (hold > 0) begin
      hold <= hold - 1;
      m_axis_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      hold <= $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // One request transfer, with an optional gap burst ahead of it
  task automatic send_request(logic [1:0] req, logic [CH_W-1:0] ch, logic [VAL_W-1:0] smp);
    if (idling && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, smp, ch};
    s_axis_tuser  <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drain all results, let the block settle, then write the scale mode
  task automatic set_scale(logic [1:0] mode);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly calibrate/normalize on valid channels; rare clears, unused codes, bad channels
  task automatic send_random();
    int               pick;
    logic [1:0]       req;
    logic [CH_W-1:0]  ch;
    logic [VAL_W-1:0] smp;
    pick = $urandom_range(0, 99);
    if (pick < 40) req = REQ_CAL;
    else if (pick < 94) req = REQ_NORM;
    else if (pick < 97) req = REQ_CLR;
    else req = REQ_NOP;
    if ($urandom_range(0, 9) == 0) ch = CH_W'($urandom_range(CHANNELS, 7));
    else ch = CH_W'($urandom_range(0, CHANNELS - 1));
    case ($urandom_range(0, 9))
      0: smp = '0;
      1: smp = '1;
      default: smp = VAL_W'($urandom_range(0, 1023));
    endcase
    send_request(req, ch, smp);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: uncalibrated, full range, div-by-zero, out-of-range, clear, unused code
    set_scale(MODE_P100);
    send_request(REQ_NORM, 3'd0, 10'd500);   // min above max: negative span
    send_request(REQ_CAL,  3'd0, 10'd0);
    send_request(REQ_CAL,  3'd0, 10'd1023);
    send_request(REQ_NORM, 3'd0, 10'd0);
    send_request(REQ_NORM, 3'd0, 10'd1023);
    send_request(REQ_NORM, 3'd0, 10'd511);
    send_request(REQ_CAL,  3'd1, 10'd300);
    send_request(REQ_NORM, 3'd1, 10'd300);   // min equals max
    send_request(REQ_CAL,  3'd1, 10'd700);
    send_request(REQ_NORM, 3'd1, 10'd100);   // below min: negative level
    send_request(REQ_NORM, 3'd1, 10'd1023);  // above max: past top
    send_request(REQ_CAL,  3'd6, 10'd5);
    send_request(REQ_NORM, 3'd7, 10'd1023);
    send_request(REQ_NOP,  3'd0, 10'd77);
    send_request(REQ_NOP,  3'd7, 10'd0);
    send_request(REQ_CLR,  3'd2, 10'd0);
    send_request(REQ_NORM, 3'd0, 10'd600);
    send_request(REQ_CLR,  3'd7, 10'd1023);
    send_request(REQ_CAL,  3'd5, 10'd1023);
    send_request(REQ_NORM, 3'd5, 10'd1023);

    // Raw passthrough, including a bad channel
    set_scale(MODE_RAW);
    send_request(REQ_NORM, 3'd7, 10'd1023);
    send_request(REQ_NORM, 3'd0, 10'd0);
    send_request(REQ_NORM, 3'd1, 10'd512);

    // Random phases, each with its own scale mode; last phase runs without idling
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1) idling = 1'b0;
      set_scale(phase < 4 ? scale_order[phase[1:0]] : scale_order[2'($urandom_range(0, 3))]);
      repeat (PHASE_ITEMS) send_random();
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
